// ===== src/necx_pkg.sv =====
`default_nettype none

package necx_pkg;

	localparam int COORD_BITS = 32;
	localparam int DIFF_BITS  = COORD_BITS + 1;
	localparam int PROD_BITS  = 2 * DIFF_BITS;

	typedef logic [1:0] quad_t;
	typedef logic [1:0] cmp_t;

	localparam quad_t QUAD_NE = 2'd0;
	localparam quad_t QUAD_NW = 2'd1;
	localparam quad_t QUAD_SW = 2'd2;
	localparam quad_t QUAD_SE = 2'd3;

	localparam cmp_t CMP_EQ = 2'd0;
	localparam cmp_t CMP_GT = 2'd1;
	localparam cmp_t CMP_LT = 2'd2;

	// sign of a*b - c*d
	typedef struct packed {
		logic gt;
		logic eq;
	} sgn_t;

	// stage advance enables handed to the determinant units
	typedef struct packed {
		logic s2;
		logic s3;
	} adv_t;

	// quadrant first, then the cross product sign
	function automatic cmp_t ang_cmp(input quad_t qp, input quad_t qq, input sgn_t s);
		cmp_t r;
		if (qp > qq) begin
			r = CMP_GT;
		end else if (qp < qq) begin
			r = CMP_LT;
		end else if (s.gt) begin
			r = CMP_GT;
		end else if (s.eq) begin
			r = CMP_EQ;
		end else begin
			r = CMP_LT;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/necx_det.sv =====
`default_nettype none

module necx_det
	import necx_pkg::*;
(
	input  wire                         clk,
	input  wire adv_t                   adv,
	input  wire logic signed [DIFF_BITS-1:0] a,
	input  wire logic signed [DIFF_BITS-1:0] b,
	input  wire logic signed [DIFF_BITS-1:0] c,
	input  wire logic signed [DIFF_BITS-1:0] d,
	output sgn_t                        sgn
);

	logic signed [PROD_BITS-1:0] ab_s2;
	logic signed [PROD_BITS-1:0] cd_s2;
	sgn_t                        sgn_s3;

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			ab_s2 <= PROD_BITS'(a) * PROD_BITS'(b);
			cd_s2 <= PROD_BITS'(c) * PROD_BITS'(d);
		end
		if (adv.s3) begin
			sgn_s3.gt <= ab_s2 > cd_s2;
			sgn_s3.eq <= ab_s2 == cd_s2;
		end
	end

	assign sgn = sgn_s3;

endmodule

`default_nettype wire

// ===== src/node_edge_crossing_test.sv =====
`default_nettype none

// channel | handshake            | payload
// --------+----------------------+------------------------------------------
// in      | in_valid / in_stall  | node_x/y, edge_{a,b}_{first,second}_{x,y}
// out     | out_valid / out_stall| crossing, degenerate
//
// Four register stages: differences, products, product compare, result.
// One beat per cycle while out_stall does not hold the pipeline; 33x33 multipliers.
// A stage advances when it is empty or the one after it advances, so
// bubbles collapse and out_stall holds only the full stages.
// arst_n clears the valid bits only.

module node_edge_crossing_test
	import necx_pkg::*;
(
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_stall,
	input  wire logic signed [COORD_BITS-1:0] node_x,
	input  wire logic signed [COORD_BITS-1:0] node_y,
	input  wire logic signed [COORD_BITS-1:0] edge_a_first_x,
	input  wire logic signed [COORD_BITS-1:0] edge_a_first_y,
	input  wire logic signed [COORD_BITS-1:0] edge_a_second_x,
	input  wire logic signed [COORD_BITS-1:0] edge_a_second_y,
	input  wire logic signed [COORD_BITS-1:0] edge_b_first_x,
	input  wire logic signed [COORD_BITS-1:0] edge_b_first_y,
	input  wire logic signed [COORD_BITS-1:0] edge_b_second_x,
	input  wire logic signed [COORD_BITS-1:0] edge_b_second_y,
	output logic                         out_valid,
	input  wire                          out_stall,
	output logic                         crossing,
	output logic                         degenerate
);

	// point order: a first, a second, b first, b second
	logic signed [COORD_BITS-1:0] px [4];
	logic signed [COORD_BITS-1:0] py [4];

	logic signed [DIFF_BITS-1:0] dx_s1 [4];
	logic signed [DIFF_BITS-1:0] dy_s1 [4];
	quad_t                       quad_s1 [4];
	quad_t                       quad_s2 [4];
	quad_t                       quad_s3 [4];
	logic                        degen_s1, degen_s2, degen_s3;
	logic                        v_s1, v_s2, v_s3, v_s4;
	logic                        crossing_s4, degenerate_s4;
	logic                        en1, en2, en3, en4;
	logic                        degen_in;
	adv_t                        adv;

	sgn_t det_aa, det_b0a0, det_b0a1, det_b1a0, det_b1a1;

	assign px[0] = edge_a_first_x;
	assign py[0] = edge_a_first_y;
	assign px[1] = edge_a_second_x;
	assign py[1] = edge_a_second_y;
	assign px[2] = edge_b_first_x;
	assign py[2] = edge_b_first_y;
	assign px[3] = edge_b_second_x;
	assign py[3] = edge_b_second_y;

	assign en4 = !v_s4 || !out_stall;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_stall = !en1;
	assign adv.s2 = en2;
	assign adv.s3 = en3;

	always_comb begin
		degen_in = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (px[i] == node_x && py[i] == node_y) begin
				degen_in = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			degen_s1 <= degen_in;
			for (int i = 0; i < 4; i++) begin
				dx_s1[i]   <= DIFF_BITS'(px[i]) - DIFF_BITS'(node_x);
				dy_s1[i]   <= DIFF_BITS'(py[i]) - DIFF_BITS'(node_y);
				quad_s1[i] <= (px[i] < node_x)
					? ((py[i] < node_y) ? QUAD_SW : QUAD_NW)
					: ((py[i] < node_y) ? QUAD_SE : QUAD_NE);
			end
		end
		if (en2) begin
			degen_s2 <= degen_s1;
			quad_s2  <= quad_s1;
		end
		if (en3) begin
			degen_s3 <= degen_s2;
			quad_s3  <= quad_s2;
		end
	end

	// cmp(p, q) in one quadrant: sign of xq*yp - yq*xp
	necx_det u_det_aa (
		.clk(clk), .adv(adv),
		.a(dx_s1[1]), .b(dy_s1[0]), .c(dy_s1[1]), .d(dx_s1[0]),
		.sgn(det_aa)
	);

	necx_det u_det_b0a0 (
		.clk(clk), .adv(adv),
		.a(dx_s1[0]), .b(dy_s1[2]), .c(dy_s1[0]), .d(dx_s1[2]),
		.sgn(det_b0a0)
	);

	necx_det u_det_b0a1 (
		.clk(clk), .adv(adv),
		.a(dx_s1[1]), .b(dy_s1[2]), .c(dy_s1[1]), .d(dx_s1[2]),
		.sgn(det_b0a1)
	);

	necx_det u_det_b1a0 (
		.clk(clk), .adv(adv),
		.a(dx_s1[0]), .b(dy_s1[3]), .c(dy_s1[0]), .d(dx_s1[3]),
		.sgn(det_b1a0)
	);

	necx_det u_det_b1a1 (
		.clk(clk), .adv(adv),
		.a(dx_s1[1]), .b(dy_s1[3]), .c(dy_s1[1]), .d(dx_s1[3]),
		.sgn(det_b1a1)
	);

	cmp_t c_aa, c_b0a0, c_b0a1, c_b1a0, c_b1a1;
	cmp_t c0_lo, c0_hi, c1_lo, c1_hi;
	logic swap, z0, z1, in0, in1, cross_d;

	always_comb begin
		c_aa   = ang_cmp(quad_s3[0], quad_s3[1], det_aa);
		c_b0a0 = ang_cmp(quad_s3[2], quad_s3[0], det_b0a0);
		c_b0a1 = ang_cmp(quad_s3[2], quad_s3[1], det_b0a1);
		c_b1a0 = ang_cmp(quad_s3[3], quad_s3[0], det_b1a0);
		c_b1a1 = ang_cmp(quad_s3[3], quad_s3[1], det_b1a1);
		swap   = c_aa == CMP_GT;
		c0_lo  = swap ? c_b0a1 : c_b0a0;
		c0_hi  = swap ? c_b0a0 : c_b0a1;
		c1_lo  = swap ? c_b1a1 : c_b1a0;
		c1_hi  = swap ? c_b1a0 : c_b1a1;
		z0     = c0_lo == CMP_EQ || c0_hi == CMP_EQ;
		z1     = c1_lo == CMP_EQ || c1_hi == CMP_EQ;
		in0    = c0_lo == CMP_GT && c0_hi == CMP_LT;
		in1    = c1_lo == CMP_GT && c1_hi == CMP_LT;
		cross_d = !degen_s3 && !z0 && !z1 && (in0 != in1);
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			crossing_s4   <= cross_d;
			degenerate_s4 <= degen_s3;
		end
	end

	assign out_valid  = v_s4;
	assign crossing   = crossing_s4;
	assign degenerate = degenerate_s4;

endmodule

`default_nettype wire
